@@ hdl/mst_pkg.sv @@
// Shared types and constants for the one-shot timer slot table.
`default_nettype none

package mst_pkg;

  localparam int CMD_W      = 2;
  localparam int TICKS_W    = 31;
  localparam int SLOT_W     = 8;
  localparam int TAG_W      = 32;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;

  // One table entry in RAM: {tag, timeout, elapsed}
  localparam int WORD_W = TAG_W + 2 * TICKS_W;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the command fields
    logic scan_clr;   // slot index back to zero
    logic scan_inc;   // next slot
    logic set_try;    // test the current slot for a set
    logic del;        // perform a delete
    logic tick_rd;    // read the current slot for a tick
    logic tick_done;  // emit the tick done result
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // index at the last slot
    logic slot_free;  // current slot not active
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/mst_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_W-1:0]    raddr,
  output      logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/mst_ctrl.sv @@
// Command sequencer for the timer slot table.
`default_nettype none

module mst_ctrl
  import mst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire sts_t             sts,
  output      logic             busy,
  output      ctl_t             ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_DEL,
    S_TICK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load     = 1'b1;
          ctl.scan_clr = 1'b1;
          case (cmd)
            CMD_TICK: state_next = S_TICK;
            CMD_SET:  state_next = S_SET;
            CMD_DEL:  state_next = S_DEL;
            default:  state_next = S_IDLE;   // unused code, no result
          endcase
        end
      end
      S_SET: begin
        ctl.set_try = 1'b1;
        if (sts.slot_free || sts.scan_last) begin
          state_next = S_IDLE;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_DEL: begin
        ctl.del    = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        ctl.tick_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;   // last slot processed in datapath
      end
      S_DONE: begin
        ctl.tick_done = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

@@ hdl/mst_dpath.sv @@
// Slot table datapath: active bits, entry RAM, scan index and result register.
`default_nettype none

module mst_dpath
  import mst_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_t                  ctl,
  output      sts_t                  sts,
  input  wire logic [TICKS_W-1:0]    ticks,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic [TAG_W-1:0]      tag,
  output      logic                  strobe,
  output      logic [KIND_W-1:0]     kind,
  output      logic [STATUS_W-1:0]   status,
  output      logic [SLOT_OUT_W-1:0] slot_out,
  output      logic [TAG_W-1:0]      tag_out,
  output      logic                  last
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(SLOT_COUNT);

  // Captured command fields
  logic [TICKS_W-1:0] lat_ticks;
  logic [SLOT_W-1:0]  lat_slot;
  logic [TAG_W-1:0]   lat_tag;

  logic [SLOT_COUNT-1:0] active;
  logic [IDX_W-1:0]      idx;
  logic                  p_valid;   // RAM read data valid for p_idx
  logic [IDX_W-1:0]      p_idx;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [WORD_W-1:0]   wdata;
  logic [WORD_W-1:0]   rdata;

  logic [TAG_W-1:0]    r_tag;
  logic [TICKS_W-1:0]  r_timeout;
  logic [TICKS_W-1:0]  r_elapsed;
  logic [TICKS_W-1:0]  elapsed_inc;
  logic                expire;
  logic                slot_ok;

  logic                  fire;
  logic [KIND_W-1:0]     kind_next;
  logic [STATUS_W-1:0]   status_next;
  logic [SLOT_OUT_W-1:0] slot_out_next;
  logic [TAG_W-1:0]      tag_out_next;
  logic                  last_next;
  logic                  act_set;
  logic                  act_clr;
  logic [IDX_W-1:0]      clr_idx;

  mst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign {r_tag, r_timeout, r_elapsed} = rdata;
  assign elapsed_inc = r_elapsed + TICKS_W'(1);   // wraps in 31 bits
  assign expire      = (r_timeout <= elapsed_inc);
  assign slot_ok     = ({1'b0, lat_slot} < SLOTS_EXT);

  assign sts.scan_last = (idx == IDX_LAST);
  assign sts.slot_free = !active[idx];

  always_comb begin
    fire          = 1'b0;
    kind_next     = KIND_SET;
    status_next   = ST_OK;
    slot_out_next = '0;
    tag_out_next  = '0;
    last_next     = 1'b1;
    we            = 1'b0;
    waddr         = idx;
    wdata         = {lat_tag, lat_ticks, {TICKS_W{1'b0}}};
    act_set       = 1'b0;
    act_clr       = 1'b0;
    clr_idx       = p_idx;

    if (ctl.set_try) begin
      if (!active[idx]) begin
        fire          = 1'b1;
        slot_out_next = SLOT_OUT_W'(idx);
        we            = 1'b1;
        act_set       = 1'b1;
      end else if (idx == IDX_LAST) begin
        fire        = 1'b1;
        status_next = ST_FULL;
      end
    end

    if (ctl.del) begin
      fire      = 1'b1;
      kind_next = KIND_DEL;
      if (slot_ok) begin
        slot_out_next = lat_slot[SLOT_OUT_W-1:0];
        act_clr       = 1'b1;
        clr_idx       = lat_slot[IDX_W-1:0];
      end else begin
        status_next = ST_BAD_SLOT;
      end
    end

    if (p_valid && active[p_idx]) begin
      if (expire) begin
        fire          = 1'b1;
        kind_next     = KIND_EXPIRE;
        slot_out_next = SLOT_OUT_W'(p_idx);
        tag_out_next  = r_tag;
        last_next     = 1'b0;
        act_clr       = 1'b1;
      end else begin
        we    = 1'b1;
        waddr = p_idx;
        wdata = {r_tag, r_timeout, elapsed_inc};
      end
    end

    if (ctl.tick_done) begin
      fire      = 1'b1;
      kind_next = KIND_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      strobe  <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      strobe  <= fire;
      p_valid <= ctl.tick_rd;
      if (act_set) begin
        active[idx] <= 1'b1;
      end
      if (act_clr) begin
        active[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lat_ticks <= ticks;
      lat_slot  <= slot;
      lat_tag   <= tag;
    end
    if (ctl.scan_clr) begin
      idx <= '0;
    end else if (ctl.scan_inc) begin
      idx <= idx + IDX_W'(1);
    end
    p_idx    <= idx;
    kind     <= kind_next;
    status   <= status_next;
    slot_out <= slot_out_next;
    tag_out  <= tag_out_next;
    last     <= last_next;
  end

`ifndef ASSERT_OFF
  // A set write and a tick write-back never compete for the RAM port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(ctl.set_try && p_valid))
    else $error("set and tick write in the same cycle");

  // An expired slot is free the cycle after
  a_expire_frees: assert property (@(posedge clk) disable iff (rst)
    (p_valid && active[p_idx] && expire) |=> !active[$past(p_idx)])
    else $error("expired slot still active");

  // Only expiries are non-final results
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (kind == KIND_EXPIRE))
    else $error("non-final result that is not an expiry");

  // Done comes only after the last slot has been processed
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.tick_done |-> ($past(p_valid) && !p_valid))
    else $error("tick done before scan drained");
`endif

endmodule

`default_nettype wire

@@ hdl/multi_slot_oneshot_timer.sv @@
// Top level of the one-shot timer slot table: controller plus datapath.
// From the start transfer: delete goes through its one state to a result; set scans one slot a cycle.
// Tick: one RAM read per slot per cycle, expiries stream out as found, done follows the drain state.
// Commands: one command at a time; busy drops as the final result shows, so the next start
//   transfers on the edge that takes that result. Results are one-cycle strobes, no stall.
// Reset (rst, synchronous) frees every slot; RAM contents need no clearing.
`default_nettype none

module multi_slot_oneshot_timer
  import mst_pkg::*;
#(
  parameter int SLOT_COUNT = 16   // 1 to 16 slots
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command side: transfer when start && !busy
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [CMD_W-1:0]      cmd,
  input  wire logic [TICKS_W-1:0]    ticks,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic [TAG_W-1:0]      tag,
  // result side: one transfer per strobe cycle
  output      logic                  strobe,
  output      logic [KIND_W-1:0]     kind,
  output      logic [STATUS_W-1:0]   status,
  output      logic [SLOT_OUT_W-1:0] slot_out,
  output      logic [TAG_W-1:0]      tag_out,
  output      logic                  last
);

  ctl_t ctl;
  sts_t sts;

  // Sequencer: idle, set scan, delete, tick scan, drain, done
  mst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Active bits in flops, timeout/elapsed/tag in one RAM word per slot.
  // Tick reads slot i while writing back slot i-1.
  mst_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .ticks    (ticks),
    .slot     (slot),
    .tag      (tag),
    .strobe   (strobe),
    .kind     (kind),
    .status   (status),
    .slot_out (slot_out),
    .tag_out  (tag_out),
    .last     (last)
  );

endmodule

`default_nettype wire
